// ----- sv/sdiv_pkg.sv -----
// Shared types and constants for the signed restoring divider.
package sdiv_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = $clog2(DATA_WIDTH);

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] dividend;
		logic signed [DATA_WIDTH-1:0] divisor;
	} in_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] quotient;
		logic signed [DATA_WIDTH-1:0] remainder;
		logic                         divide_by_zero;
	} out_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cmd_t;

endpackage

// ----- sv/signed_restoring_divider.sv -----
// Top level of the signed restoring divider: controller plus datapath.
//
//  channel   direction  handshake             payload
//  in        input      in_valid / in_stall   sdiv_pkg::in_t  (dividend, divisor)
//  out       output     out_valid / out_stall sdiv_pkg::out_t (quotient, remainder, divide_by_zero)
//
// One transaction runs a load, one shift-subtract step per quotient bit through the single
// subtractor, and a fix-up that writes the output register.
// A new transaction is taken while the previous result waits in the output register.
// If the output register is still full and stalled, the fix-up waits for it.
// Reset clears the controller and the output valid; payload registers are not reset.
module signed_restoring_divider (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  sdiv_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output sdiv_pkg::out_t out_data
);

	sdiv_pkg::cmd_t cmd;

	sdiv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	sdiv_dpath u_dpath (
		.clk      (clk),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

// ----- sv/sdiv_ctrl.sv -----
// Controller state machine for the signed restoring divider.
module sdiv_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  logic          out_stall,
	output sdiv_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_BUSY = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]               state_q;
	logic [sdiv_pkg::CNT_W-1:0] cnt_q;
	logic                     out_valid_q;
	logic                     out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Decode commands for the datapath
	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.step   = (state_q == ST_BUSY);
		cmd.finish = (state_q == ST_DONE) && out_free;
	end

	// Sequence one transaction: load, one step per quotient bit, then fix up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_BUSY;
						cnt_q   <= sdiv_pkg::CNT_W'(sdiv_pkg::DATA_WIDTH - 1);
					end
				end
				ST_BUSY: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - sdiv_pkg::CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Raise valid on a new result, drop it once the transaction is taken
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/sdiv_dpath.sv -----
// Datapath for the signed restoring divider: magnitudes, shift-subtract step, sign fix-up.
module sdiv_dpath (
	input  logic           clk,
	input  sdiv_pkg::cmd_t cmd,
	input  sdiv_pkg::in_t  in_data,
	output sdiv_pkg::out_t out_data
);

	localparam int W = sdiv_pkg::DATA_WIDTH;

	logic [W-1:0] rem_q;
	logic [W-1:0] quo_q;
	logic [W-1:0] den_q;
	logic [W-1:0] dvd_q;
	logic         neg_q;
	logic         aneg_q;
	logic         dbz_q;
	sdiv_pkg::out_t out_q;

	logic [W-1:0] a_mag;
	logic [W-1:0] b_mag;
	logic [W:0]   partial;
	logic [W:0]   trial;
	logic [W-1:0] quo_fix;
	logic [W-1:0] rem_fix;

	// Take magnitudes of the operands
	assign a_mag = in_data.dividend[W-1] ? (W'(0) - W'(in_data.dividend)) : W'(in_data.dividend);
	assign b_mag = in_data.divisor[W-1] ? (W'(0) - W'(in_data.divisor)) : W'(in_data.divisor);

	// Trial subtract of the aligned divisor
	assign partial = {rem_q, quo_q[W-1]};
	assign trial   = partial - {1'b0, den_q};

	// Apply signs to the unsigned results
	assign quo_fix = neg_q ? (W'(0) - quo_q) : quo_q;
	assign rem_fix = aneg_q ? (W'(0) - rem_q) : rem_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q  <= '0;
			quo_q  <= a_mag;
			den_q  <= b_mag;
			dvd_q  <= in_data.dividend;
			neg_q  <= in_data.dividend[W-1] ^ in_data.divisor[W-1];
			aneg_q <= in_data.dividend[W-1];
			dbz_q  <= (in_data.divisor == '0);
		end else if (cmd.step) begin
			// Keep the difference when no borrow, restore otherwise
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= partial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end

		// Capture the finished result, fixed values for a zero divisor
		if (cmd.finish) begin
			if (dbz_q) begin
				out_q.quotient       <= '1;
				out_q.remainder      <= dvd_q;
				out_q.divide_by_zero <= 1'b1;
			end else begin
				out_q.quotient       <= quo_fix;
				out_q.remainder      <= rem_fix;
				out_q.divide_by_zero <= 1'b0;
			end
		end
	end

	assign out_data = out_q;

endmodule

// ----- sv/sdiv_checker.sv -----
// Port-level assertions for the signed restoring divider, bound to the top level.
module sdiv_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input sdiv_pkg::in_t  in_data,
	input logic           out_valid,
	input logic           out_stall,
	input sdiv_pkg::out_t out_data
);

	// Hold a stalled result valid
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// Hold a stalled result payload
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("out_data changed while stalled");

	// Check that the input is still stalled after the last step of an accepted transaction
	a_busy_span: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> ##(sdiv_pkg::DATA_WIDTH + 1) in_stall)
		else $error("input taken before the division finished");

	// Flag a zero divisor with an all-ones quotient
	a_dbz_quotient: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.divide_by_zero |-> out_data.quotient == '1)
		else $error("divide by zero without all-ones quotient");

endmodule

bind signed_restoring_divider sdiv_checker u_sdiv_checker (.*);
